// ===== rtl/ip5t_pkg.sv =====
`default_nettype none

package ip5t_pkg;

  // Layer kind found at the first IP byte
  localparam logic [1:0] VK_UNKNOWN = 2'd0;
  localparam logic [1:0] VK_IPV4    = 2'd1;
  localparam logic [1:0] VK_IPV6    = 2'd2;
  localparam logic [1:0] VK_OTHER   = 2'd3;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [3:0] IP_VERSION_6 = 4'd6;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [1:0] KIND_TCP    = 2'd0;
  localparam logic [1:0] KIND_UDP    = 2'd1;
  localparam logic [1:0] KIND_ICMP   = 2'd2;
  localparam logic [1:0] KIND_ICMPV6 = 2'd3;

  localparam logic [6:0] IPV4_BASE_LEN  = 7'd20;
  localparam logic [6:0] IPV6_HDR_LEN   = 7'd40;
  localparam logic [6:0] IPV6_PORTS_END = 7'd44;
  localparam logic [6:0] PORTS_LEN      = 7'd4;

  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;
  localparam logic [7:0]  LINK_HEADER_RESET = 8'd14;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] wire_length;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        is_ipv6;
    logic [1:0]  protocol_kind;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [63:0] src_address_high;
    logic [63:0] src_address_low;
    logic [63:0] dst_address_high;
    logic [63:0] dst_address_low;
    logic [15:0] packet_length;
  } result_t;

  function automatic logic [1:0] decode_version(input logic [3:0] nibble);
    logic [1:0] vk;
    if (nibble == IP_VERSION_4) begin
      vk = VK_IPV4;
    end else if (nibble == IP_VERSION_6) begin
      vk = VK_IPV6;
    end else begin
      vk = VK_OTHER;
    end
    return vk;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ip_five_tuple_parser_core.sv =====
// IP five-tuple header parser.
// Input channel (in_valid / in_stall): one byte of a captured frame per item,
// in wire order; last_byte marks the final byte, and wire_length is sampled
// with it. The first link_header_bytes bytes are skipped; the IP version
// nibble then selects IPv4 (IHL locates the ports) or IPv6 (fixed 40-byte
// header, no extension-header walk).
// Output channel (out_valid / out_stall): exactly one item per frame, made
// on its last byte: accepted, family, protocol kind, ports, raw addresses
// and packet length. A rejected or truncated frame gives an all-zero item.
// Configuration: cfg_write_enable / cfg_write_data load link_header_bytes
// (reset value 14); write it only between frames.
// Path: a last byte is held in the input register, then the parse logic writes
// its result into the result register that drives the output ports.
// Throughput: one byte per cycle while in_stall is low; the per-byte work is
// an offset compare and a byte capture into the frame registers.
// Reset (rst, synchronous): clears the frame state, both valid flags and
// restores link_header_bytes to 14.
// Stall: bytes that are not last keep flowing into the frame state; a last
// byte waits in the input register while the result register is full and
// stalled, and in_stall is raised until the result register frees up.
`default_nettype none

module ip_five_tuple_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [7:0]  cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] wire_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic             is_ipv6,
  output logic [1:0]       protocol_kind,
  output logic [15:0]      source_port,
  output logic [15:0]      destination_port,
  output logic [63:0]      src_address_high,
  output logic [63:0]      src_address_low,
  output logic [63:0]      dst_address_high,
  output logic [63:0]      dst_address_low,
  output logic [15:0]      packet_length
);
  import ip5t_pkg::*;

  logic [7:0] link_header_bytes;
  in_item_t   in_item;
  in_item_t   held_item;
  logic       held_valid;
  logic       advance;
  logic       out_free;
  logic       emit;
  result_t    parse_result;
  result_t    out_item;

  assign in_item.data_byte   = data_byte;
  assign in_item.last_byte   = last_byte;
  assign in_item.wire_length = wire_length;

  // A held byte moves on unless it closes a frame and the result slot is busy
  assign advance = held_valid && (!held_item.last_byte || out_free);
  assign emit    = advance && held_item.last_byte;

  ip5t_link_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_write_data    (cfg_write_data),
    .link_header_bytes (link_header_bytes)
  );

  ip5t_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ip5t_parse u_parse (
    .clk               (clk),
    .rst               (rst),
    .link_header_bytes (link_header_bytes),
    .step              (advance),
    .item              (held_item),
    .result            (parse_result)
  );

  ip5t_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_item (parse_result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign accepted         = out_item.accepted;
  assign is_ipv6          = out_item.is_ipv6;
  assign protocol_kind    = out_item.protocol_kind;
  assign source_port      = out_item.source_port;
  assign destination_port = out_item.destination_port;
  assign src_address_high = out_item.src_address_high;
  assign src_address_low  = out_item.src_address_low;
  assign dst_address_high = out_item.dst_address_high;
  assign dst_address_low  = out_item.dst_address_low;
  assign packet_length    = out_item.packet_length;

endmodule

`default_nettype wire

// ===== rtl/ip5t_in_reg.sv =====
`default_nettype none

module ip5t_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ip5t_pkg::in_item_t in_item,
  input  wire logic              advance,
  output logic                   held_valid,
  output ip5t_pkg::in_item_t     held_item
);
  import ip5t_pkg::*;

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ip5t_parse.sv =====
`default_nettype none

module ip5t_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         link_header_bytes,
  input  wire logic               step,
  input  wire ip5t_pkg::in_item_t item,
  output ip5t_pkg::result_t       result
);
  import ip5t_pkg::*;

  logic [15:0] byte_offset, byte_offset_next;
  logic [1:0]  version_kind, version_kind_next;
  logic [3:0]  ipv4_header_words, ipv4_header_words_next;
  logic [7:0]  protocol_byte, protocol_byte_next;
  logic [63:0] src_high, src_high_next, src_low, src_low_next;
  logic [63:0] dst_high, dst_high_next, dst_low, dst_low_next;
  logic [15:0] source_port_reg, source_port_next;
  logic [15:0] destination_port_reg, destination_port_next;

  logic        in_hdr;
  logic [15:0] rel;
  logic [15:0] rel_port;
  logic [5:0]  port_base;
  logic        port_hit;
  logic [1:0]  port_k;
  logic [7:0]  b;
  logic [6:0]  need;
  logic [6:0]  ports_end;
  logic [1:0]  kind;
  logic        ok;
  logic        have_ok;

  assign b      = item.data_byte;
  assign in_hdr = byte_offset >= {8'd0, link_header_bytes};
  assign rel    = byte_offset - {8'd0, link_header_bytes};

  // Frame state update for one byte
  always_comb begin
    version_kind_next      = version_kind;
    ipv4_header_words_next = ipv4_header_words;
    protocol_byte_next     = protocol_byte;
    src_high_next          = src_high;
    src_low_next           = src_low;
    dst_high_next          = dst_high;
    dst_low_next           = dst_low;
    source_port_next       = source_port_reg;
    destination_port_next  = destination_port_reg;
    port_hit               = 1'b0;
    port_k                 = 2'd0;

    if (in_hdr && rel == 16'd0) begin
      version_kind_next      = decode_version(b[7:4]);
      ipv4_header_words_next = b[3:0];
    end

    port_base = {ipv4_header_words_next, 2'b00};
    rel_port  = rel - {10'd0, port_base};

    if (in_hdr && version_kind_next == VK_IPV4) begin
      if (rel == 16'd9) protocol_byte_next = b;
      if (rel >= 16'd12 && rel <= 16'd15) src_low_next = {32'd0, src_low[23:0], b};
      if (rel >= 16'd16 && rel <= 16'd19) dst_low_next = {32'd0, dst_low[23:0], b};
      if (rel >= {10'd0, port_base} && rel_port < 16'd4) begin
        port_hit = 1'b1;
        port_k   = rel_port[1:0];
      end
    end else if (in_hdr && version_kind_next == VK_IPV6) begin
      if (rel == 16'd6) protocol_byte_next = b;
      if (rel >= 16'd8  && rel <= 16'd15) src_high_next = {src_high[55:0], b};
      if (rel >= 16'd16 && rel <= 16'd23) src_low_next  = {src_low[55:0], b};
      if (rel >= 16'd24 && rel <= 16'd31) dst_high_next = {dst_high[55:0], b};
      if (rel >= 16'd32 && rel <= 16'd39) dst_low_next  = {dst_low[55:0], b};
      if (rel >= 16'd40 && rel <= 16'd43) begin
        port_hit = 1'b1;
        port_k   = rel[1:0];
      end
    end

    if (port_hit) begin
      if (!port_k[1]) begin
        source_port_next = {source_port_reg[7:0], b};
      end else begin
        destination_port_next = {destination_port_reg[7:0], b};
      end
    end

    byte_offset_next = (byte_offset < OFFSET_MAX) ? byte_offset + 16'd1 : byte_offset;
  end

  // Verdict on the state after this byte
  always_comb begin
    ok        = 1'b0;
    kind      = KIND_TCP;
    need      = 7'd0;
    ports_end = {1'b0, ipv4_header_words_next, 2'b00} + PORTS_LEN;

    if (version_kind_next == VK_IPV4) begin
      ok = 1'b1;
      case (protocol_byte_next)
        PROTO_TCP:  begin kind = KIND_TCP;  need = ports_end;     end
        PROTO_UDP:  begin kind = KIND_UDP;  need = ports_end;     end
        PROTO_ICMP: begin kind = KIND_ICMP; need = IPV4_BASE_LEN; end
        default:    ok = 1'b0;
      endcase
      if (need < IPV4_BASE_LEN) need = IPV4_BASE_LEN;
    end else if (version_kind_next == VK_IPV6) begin
      ok = 1'b1;
      case (protocol_byte_next)
        PROTO_TCP:    begin kind = KIND_TCP;    need = IPV6_PORTS_END; end
        PROTO_UDP:    begin kind = KIND_UDP;    need = IPV6_PORTS_END; end
        PROTO_ICMPV6: begin kind = KIND_ICMPV6; need = IPV6_HDR_LEN;   end
        default:      ok = 1'b0;
      endcase
    end

    // bytes seen = rel + 1; need is at least 20 whenever ok is set
    have_ok = in_hdr && (rel >= {9'd0, need - 7'd1});

    result = '0;
    if (ok && have_ok) begin
      result.accepted         = 1'b1;
      result.is_ipv6          = (version_kind_next == VK_IPV6);
      result.protocol_kind    = kind;
      result.source_port      = kind[1] ? 16'd0 : source_port_next;
      result.destination_port = kind[1] ? 16'd0 : destination_port_next;
      result.src_address_high = src_high_next;
      result.src_address_low  = src_low_next;
      result.dst_address_high = dst_high_next;
      result.dst_address_low  = dst_low_next;
      result.packet_length    = item.wire_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_offset          <= '0;
      version_kind         <= VK_UNKNOWN;
      ipv4_header_words    <= '0;
      protocol_byte        <= '0;
      src_high             <= '0;
      src_low              <= '0;
      dst_high             <= '0;
      dst_low              <= '0;
      source_port_reg      <= '0;
      destination_port_reg <= '0;
    end else if (step) begin
      byte_offset          <= byte_offset_next;
      version_kind         <= version_kind_next;
      ipv4_header_words    <= ipv4_header_words_next;
      protocol_byte        <= protocol_byte_next;
      src_high             <= src_high_next;
      src_low              <= src_low_next;
      dst_high             <= dst_high_next;
      dst_low              <= dst_low_next;
      source_port_reg      <= source_port_next;
      destination_port_reg <= destination_port_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ip5t_out_reg.sv =====
`default_nettype none

module ip5t_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire ip5t_pkg::result_t load_item,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ip5t_pkg::result_t      out_item
);
  import ip5t_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ip5t_five_tuple_parser_core_placeholder.sv =====
`default_nettype none

// Link header length register: reset to the Ethernet header size, written
// from the configuration port.
module ip5t_link_cfg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_enable,
  input  wire logic [7:0] cfg_write_data,
  output logic [7:0]      link_header_bytes
);
  import ip5t_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_header_bytes <= LINK_HEADER_RESET;
    end else if (cfg_write_enable) begin
      link_header_bytes <= cfg_write_data;
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ip5t_pkg::*;

  // Run budget in clock cycles; the slowest correct run stays well below it.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Keep every byte of the built frame.
  localparam int KEEP_ALL = -1;

  // How the don't-care header bytes get filled.
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_mode_t;

  // ---------------------------------------------------------------------------
  // Block ports
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [7:0]  cfg_write_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic [15:0] wire_length = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic        is_ipv6;
  logic [1:0]  protocol_kind;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [63:0] src_address_high;
  logic [63:0] src_address_low;
  logic [63:0] dst_address_high;
  logic [63:0] dst_address_low;
  logic [15:0] packet_length;

  ip_five_tuple_parser_core uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .wire_length      (wire_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .accepted         (accepted),
    .is_ipv6          (is_ipv6),
    .protocol_kind    (protocol_kind),
    .source_port      (source_port),
    .destination_port (destination_port),
    .src_address_high (src_address_high),
    .src_address_low  (src_address_low),
    .dst_address_high (dst_address_high),
    .dst_address_low  (dst_address_low),
    .packet_length    (packet_length)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  in_item_t    frame_bytes[$];       // bytes waiting for the driver
  result_t     expected_tuples[$];   // predicted result items, oldest first
  logic [7:0]  ip_hdr[$];            // scratch frame built by the generators

  int          fail_count = 0;
  int          cycle_count = 0;
  int          ip_bytes_queued = 0;  // bytes past the link header, for phase budgets
  int          link_setting = LINK_HEADER_RESET;  // header length the generators assume
  bit          byte_taken = 1'b0;    // an item was accepted at the last rising edge
  bit          tx_idle_en = 1'b1;    // allow gaps between input items
  bit          rx_idle_en = 1'b1;    // allow stalls on the result side
  int          gap_left = 0;
  int          stall_hold = 0;

  // Predictor copy of the parser state.
  logic [7:0]  hdr_skip = LINK_HEADER_RESET;
  logic [15:0] frame_pos;
  logic [1:0]  layer;
  logic [3:0]  ihl_words;
  logic [7:0]  proto_byte;
  logic [63:0] src_addr[2];          // index 0 high word, index 1 low word
  logic [63:0] dst_addr[2];
  logic [15:0] sport_acc;
  logic [15:0] dport_acc;

  // Free-running clock, 20 ns period.
  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Five-tuple predictor
  // ---------------------------------------------------------------------------

  // Drop everything learned about the current frame.
  task automatic clear_frame_state();
    frame_pos  = '0;
    layer      = VK_UNKNOWN;
    ihl_words  = '0;
    proto_byte = '0;
    src_addr[0] = '0;
    src_addr[1] = '0;
    dst_addr[0] = '0;
    dst_addr[1] = '0;
    sport_acc  = '0;
    dport_acc  = '0;
  endtask

  // Shift a port byte into source (first two) or destination (last two).
  task automatic capture_port_byte(input int unsigned idx, input logic [7:0] b);
    if (idx < 2) begin
      sport_acc = {sport_acc[7:0], b};
    end else begin
      dport_acc = {dport_acc[7:0], b};
    end
  endtask

  // Capture one byte at IP-relative position rel.
  task automatic capture_ip_byte(input int unsigned rel, input logic [7:0] b);
    int unsigned p;
    if (rel == 0) begin
      ihl_words = b[3:0];
      if (b[7:4] == IP_VERSION_4) begin
        layer = VK_IPV4;
      end else if (b[7:4] == IP_VERSION_6) begin
        layer = VK_IPV6;
      end else begin
        layer = VK_OTHER;
      end
    end
    p = 4 * ihl_words;
    if (layer == VK_IPV4) begin
      if (rel == 9) proto_byte = b;
      // IPv4 addresses live in the low 32 bits only.
      if (rel >= 12 && rel <= 15) src_addr[1] = {32'd0, src_addr[1][23:0], b};
      if (rel >= 16 && rel <= 19) dst_addr[1] = {32'd0, dst_addr[1][23:0], b};
      // IHL is not range checked: a small IHL lands the ports inside the header.
      if (rel >= p && rel <= p + 3) capture_port_byte(rel - p, b);
    end else if (layer == VK_IPV6) begin
      if (rel == 6) proto_byte = b;
      if (rel >= 8 && rel <= 15)  src_addr[0] = {src_addr[0][55:0], b};
      if (rel >= 16 && rel <= 23) src_addr[1] = {src_addr[1][55:0], b};
      if (rel >= 24 && rel <= 31) dst_addr[0] = {dst_addr[0][55:0], b};
      if (rel >= 32 && rel <= 39) dst_addr[1] = {dst_addr[1][55:0], b};
      if (rel >= 40 && rel <= 43) capture_port_byte(rel - 40, b);
    end
  endtask

  // Advance the parser by one accepted byte; on the last byte, build the tuple.
  task automatic predict_byte(input logic [7:0] b, input logic last, input logic [15:0] wlen,
                              output bit emits, output result_t tuple);
    int unsigned rel;
    int unsigned have;
    int unsigned need;
    logic [1:0]  kind;
    bit          ok;
    have  = 0;
    need  = 0;
    kind  = KIND_TCP;
    ok    = 1'b0;
    emits = 1'b0;
    tuple = '0;
    if (frame_pos >= hdr_skip) begin
      rel = frame_pos - hdr_skip;
      capture_ip_byte(rel, b);
      have = rel + 1;
    end
    // Saturate the offset on very long frames.
    if (frame_pos != OFFSET_MAX) frame_pos = frame_pos + 1'b1;
    if (last) begin
      emits = 1'b1;
      if (layer == VK_IPV4) begin
        ok = 1'b1;
        case (proto_byte)
          PROTO_TCP: begin
            kind = KIND_TCP;
            need = 4 * ihl_words + PORTS_LEN;
          end
          PROTO_UDP: begin
            kind = KIND_UDP;
            need = 4 * ihl_words + PORTS_LEN;
          end
          PROTO_ICMP: begin
            kind = KIND_ICMP;
            need = IPV4_BASE_LEN;
          end
          default: ok = 1'b0;
        endcase
        if (need < IPV4_BASE_LEN) need = IPV4_BASE_LEN;
      end else if (layer == VK_IPV6) begin
        ok = 1'b1;
        case (proto_byte)
          PROTO_TCP: begin
            kind = KIND_TCP;
            need = IPV6_PORTS_END;
          end
          PROTO_UDP: begin
            kind = KIND_UDP;
            need = IPV6_PORTS_END;
          end
          PROTO_ICMPV6: begin
            kind = KIND_ICMPV6;
            need = IPV6_HDR_LEN;
          end
          default: ok = 1'b0;
        endcase
      end
      // Truncated frames are rejected.
      if (have < need) ok = 1'b0;
      if (ok) begin
        tuple.accepted      = 1'b1;
        tuple.is_ipv6       = (layer == VK_IPV6);
        tuple.protocol_kind = kind;
        if (kind == KIND_TCP || kind == KIND_UDP) begin
          tuple.source_port      = sport_acc;
          tuple.destination_port = dport_acc;
        end
        tuple.src_address_high = src_addr[0];
        tuple.src_address_low  = src_addr[1];
        tuple.dst_address_high = dst_addr[0];
        tuple.dst_address_low  = dst_addr[1];
        tuple.packet_length    = wlen;
      end
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_tuple();
    result_t want;
    if (expected_tuples.size() == 0) begin
      $error("result item with no frame end pending");
      fail_count++;
      return;
    end
    want = expected_tuples.pop_front();
    check_field("accepted", want.accepted, accepted);
    check_field("is_ipv6", want.is_ipv6, is_ipv6);
    check_field("protocol_kind", want.protocol_kind, protocol_kind);
    check_field("source_port", want.source_port, source_port);
    check_field("destination_port", want.destination_port, destination_port);
    check_field("src_address_high", want.src_address_high, src_address_high);
    check_field("src_address_low", want.src_address_low, src_address_low);
    check_field("dst_address_high", want.dst_address_high, dst_address_high);
    check_field("dst_address_low", want.dst_address_low, dst_address_low);
    check_field("packet_length", want.packet_length, packet_length);
  endtask

  // Monitor: sample at the rising edge. Check the outgoing result first, then
  // advance the predictor with the byte taken at this same edge. The byte
  // taken now cannot produce the result seen now, so the order is safe.
  always @(posedge clk) begin : watch_ports
    result_t predicted;
    bit      emits;
    if (rst) begin
      byte_taken <= 1'b0;
      hdr_skip = LINK_HEADER_RESET;
      clear_frame_state();
    end else begin
      byte_taken <= in_valid && !in_stall;
      // Track the link header length exactly when the block loads it.
      if (cfg_write_enable) hdr_skip = cfg_write_data;
      if (out_valid && !out_stall) check_tuple();
      if (in_valid && !in_stall) begin
        predict_byte(data_byte, last_byte, wire_length, emits, predicted);
        if (emits) expected_tuples.push_back(predicted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle timing
  // ---------------------------------------------------------------------------

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(0, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Byte driver: change inputs on the falling edge only. Hold the current
  // item until it is taken, then either pause or advance to the next byte.
  always @(negedge clk) begin : drive_bytes
    in_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (frame_bytes.size() != 0) begin
        nxt = frame_bytes.pop_front();
        data_byte   <= nxt.data_byte;
        last_byte   <= nxt.last_byte;
        wire_length <= nxt.wire_length;
        in_valid    <= 1'b1;
        gap_left = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall: alternate runs of ready and stalled cycles.
  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (!rx_idle_en) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_hold = idle_len();
    end else begin
      out_stall <= 1'b0;
      stall_hold = $urandom_range(0, 8);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame generators
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] filler(input fill_mode_t fill);
    if (fill == FILL_ONES) return 8'hFF;
    if (fill == FILL_ZEROS) return 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_wlen();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // IPv4 header long enough to reach the ports, plus tail payload bytes.
  task automatic build_ipv4(input logic [3:0] ihl, input logic [7:0] proto, input int tail,
                            input fill_mode_t fill);
    int hlen;
    hlen = 4 * ihl + PORTS_LEN;
    if (hlen < IPV4_BASE_LEN) hlen = IPV4_BASE_LEN;
    ip_hdr = {};
    for (int i = 0; i < hlen + tail; i++) ip_hdr.push_back(filler(fill));
    ip_hdr[0] = {IP_VERSION_4, ihl};
    ip_hdr[9] = proto;
  endtask

  // Fixed 40-byte IPv6 header, four port bytes, then tail payload bytes.
  task automatic build_ipv6(input logic [7:0] next_hdr, input int tail, input fill_mode_t fill);
    ip_hdr = {};
    for (int i = 0; i < IPV6_PORTS_END + tail; i++) ip_hdr.push_back(filler(fill));
    ip_hdr[0] = {IP_VERSION_6, ip_hdr[0][3:0]};
    ip_hdr[6] = next_hdr;
  endtask

  // Anything whose version nibble is neither 4 nor 6.
  task automatic build_other(input logic [3:0] ver, input int len);
    ip_hdr = {};
    for (int i = 0; i < len; i++) ip_hdr.push_back(filler(FILL_RANDOM));
    ip_hdr[0] = {ver, ip_hdr[0][3:0]};
  endtask

  // Prepend a random link header, cut to keep bytes if asked, and queue the
  // frame with last_byte on its final byte.
  task automatic queue_frame(input int keep, input logic [15:0] wlen);
    logic [7:0] fb[$];
    in_item_t   it;
    int         total;
    fb = {};
    repeat (link_setting) fb.push_back(8'($urandom));
    foreach (ip_hdr[i]) fb.push_back(ip_hdr[i]);
    if (fb.size() == 0) fb.push_back(8'($urandom));
    total = (keep >= 0 && keep < fb.size()) ? keep : fb.size();
    if (total < 1) total = 1;
    for (int i = 0; i < total; i++) begin
      it.data_byte   = fb[i];
      it.last_byte   = (i == total - 1);
      it.wire_length = it.last_byte ? wlen : 16'($urandom);
      frame_bytes.push_back(it);
    end
    if (total > link_setting) ip_bytes_queued += total - link_setting;
  endtask

  // One random frame: mostly well-formed IPv4 or IPv6 with random content,
  // the rest foreign versions, raw noise and truncated frames.
  task automatic random_frame();
    int         roll;
    int         tail;
    int         keep;
    logic [3:0] ihl;
    logic [7:0] proto;
    roll = $urandom_range(0, 99);
    tail = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    if (roll < 40) begin
      case ($urandom_range(0, 9))
        0, 1:    ihl = 4'($urandom_range(6, 15));
        2:       ihl = 4'($urandom_range(0, 4));
        default: ihl = 4'd5;
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: proto = PROTO_TCP;
        6, 7, 8, 9, 10, 11: proto = PROTO_UDP;
        12, 13, 14, 15, 16: proto = PROTO_ICMP;
        default: proto = 8'($urandom);
      endcase
      build_ipv4(ihl, proto, tail, FILL_RANDOM);
    end else if (roll < 75) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: proto = PROTO_TCP;
        6, 7, 8, 9, 10, 11: proto = PROTO_UDP;
        12, 13, 14, 15, 16: proto = PROTO_ICMPV6;
        default: proto = 8'($urandom);
      endcase
      build_ipv6(proto, tail, FILL_RANDOM);
    end else if (roll < 85) begin
      do ihl = 4'($urandom); while (ihl == IP_VERSION_4 || ihl == IP_VERSION_6);
      build_other(ihl, $urandom_range(1, 60));
    end else begin
      // raw noise; a 4 or 6 in front makes a broken header
      build_other(4'($urandom), $urandom_range(1, 60));
    end
    // Cut about one frame in eight somewhere inside the IP part.
    keep = ($urandom_range(0, 7) == 0) ? link_setting + $urandom_range(0, ip_hdr.size())
                                       : KEEP_ALL;
    queue_frame(keep, pick_wlen());
  endtask

  task automatic random_phase(input int min_frames, input int min_bytes);
    int frames;
    int start_bytes;
    frames = 0;
    start_bytes = ip_bytes_queued;
    while (frames < min_frames || ip_bytes_queued - start_bytes < min_bytes) begin
      random_frame();
      frames++;
    end
  endtask

  // Wait until every byte went in and every result came out, then let the
  // two-stage pipeline settle before touching the register.
  task automatic wait_idle();
    forever begin
      @(posedge clk);
      #1;
      if (frame_bytes.size() == 0 && !in_valid && expected_tuples.size() == 0) break;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_link_header(input logic [7:0] value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    link_setting = value;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames at the reset link header length.
    build_ipv4(4'd5, PROTO_TCP, 0, FILL_ONES);        // all-ones addresses and ports
    queue_frame(KEEP_ALL, 16'hFFFF);
    build_ipv4(4'd5, PROTO_UDP, 3, FILL_ZEROS);       // all-zero addresses and ports
    queue_frame(KEEP_ALL, 16'h0000);
    build_ipv4(4'd5, PROTO_ICMP, 4, FILL_RANDOM);     // ICMP ending right at the base header
    queue_frame(link_setting + IPV4_BASE_LEN, pick_wlen());
    build_ipv4(4'd5, PROTO_ICMP, 4, FILL_RANDOM);     // ICMP one byte short
    queue_frame(link_setting + IPV4_BASE_LEN - 1, pick_wlen());
    build_ipv4(4'd5, PROTO_TCP, 0, FILL_RANDOM);      // TCP missing the last port byte
    queue_frame(link_setting + 23, pick_wlen());
    build_ipv4(4'd15, PROTO_UDP, 2, FILL_RANDOM);     // largest IHL
    queue_frame(KEEP_ALL, pick_wlen());
    build_ipv4(4'd0, PROTO_TCP, 0, FILL_RANDOM);      // IHL zero: ports overlap the header
    queue_frame(KEEP_ALL, pick_wlen());
    build_ipv4(4'd3, PROTO_UDP, 1, FILL_RANDOM);      // small IHL
    queue_frame(KEEP_ALL, pick_wlen());
    build_ipv4(4'd5, PROTO_ICMPV6, 4, FILL_RANDOM);   // unsupported IPv4 protocol
    queue_frame(KEEP_ALL, pick_wlen());
    build_ipv6(PROTO_TCP, 0, FILL_ONES);
    queue_frame(KEEP_ALL, 16'hFFFF);
    build_ipv6(PROTO_UDP, 5, FILL_ZEROS);
    queue_frame(KEEP_ALL, 16'h0000);
    build_ipv6(PROTO_ICMPV6, 0, FILL_RANDOM);         // ICMPv6 ending right at 40 bytes
    queue_frame(link_setting + IPV6_HDR_LEN, pick_wlen());
    build_ipv6(PROTO_ICMPV6, 0, FILL_RANDOM);         // ICMPv6 one byte short
    queue_frame(link_setting + IPV6_HDR_LEN - 1, pick_wlen());
    build_ipv6(PROTO_TCP, 0, FILL_RANDOM);            // IPv6 TCP missing a port byte
    queue_frame(link_setting + IPV6_PORTS_END - 1, pick_wlen());
    build_ipv6(PROTO_ICMP, 3, FILL_RANDOM);           // unsupported next header
    queue_frame(KEEP_ALL, pick_wlen());
    build_other(4'd5, 30);                            // foreign version
    queue_frame(KEEP_ALL, pick_wlen());
    build_ipv4(4'd5, PROTO_TCP, 0, FILL_RANDOM);      // frame ends inside the link header
    queue_frame(3, pick_wlen());
    queue_frame(1, pick_wlen());                      // single-byte frame
    wait_idle();

    // Random frames across several link header settings, extremes included.
    write_link_header(8'd0);
    random_phase(4, 0);
    wait_idle();

    write_link_header(8'd255);
    random_phase(1, 0);
    wait_idle();

    // A stretch with no idling on either side.
    write_link_header(8'd1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_phase(3, 0);
    wait_idle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ip5t_pkg.sv
rtl/ip5t_in_reg.sv
rtl/ip5t_parse.sv
rtl/ip5t_out_reg.sv
rtl/ip5t_five_tuple_parser_core_placeholder.sv
rtl/ip_five_tuple_parser_core.sv
verif/testbench.sv
